// ===== rtl/blpd_pkg.sv =====
// shared types and constants for the button long-press detector
// no dependencies; used by the top level, blpd_in_stage and blpd_core
`default_nettype none

package blpd_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int COUNT_W     = 8;

  // button positions in the pressed and pulse vectors
  localparam int BTN_STAR  = 0;
  localparam int BTN_NUM   = 1;
  localparam int BTN_UP    = 2;
  localparam int BTN_DOWN  = 3;
  localparam int BTN_LIGHT = 4;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(2);

  typedef logic [COUNT_W-1:0] count_t;

  // one sampled tick held in the input register
  typedef struct packed {
    logic                   valid;
    logic [NUM_BUTTONS-1:0] pressed;
  } stage_t;

  // one result word
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] long_pulse;
    logic                   mute_state;
    logic                   lock_state;
    logic                   mute_toggled;
    logic                   lock_toggled;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/button_long_press_detector.sv =====
// top level of the button long-press detector: threshold register and the two stages
// depends on blpd_pkg, blpd_in_stage and blpd_core
`default_nettype none

// One word per tick of five button levels goes in, one result word comes out. A new
// word is taken every clock cycle while in_stall is low; the input register frees up in
// the cycle its word passes into the result register, so the block keeps taking words
// while one result waits on out_stall, and holds in_stall only when both registers are
// full. All counters update in the single cycle a word moves from the input register to
// the result register. threshold resets to 2; the user writes it through cfg_write
// and cfg_data while the block is idle (not enforced); at 255 no press ever fires.
module button_long_press_detector (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       star_pressed,
  input  wire logic       num_pressed,
  input  wire logic       up_pressed,
  input  wire logic       down_pressed,
  input  wire logic       light_pressed,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            star_press_long,
  output logic            num_press_long,
  output logic            up_long,
  output logic            down_press_long,
  output logic            light_long,
  output logic            mute_state,
  output logic            lock_state,
  output logic            mute_toggled,
  output logic            lock_toggled
);

  blpd_pkg::count_t  threshold;
  blpd_pkg::stage_t  stage;
  blpd_pkg::result_t result;
  logic              take;
  logic [blpd_pkg::NUM_BUTTONS-1:0] pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= blpd_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  always_comb begin
    pressed                      = '0;
    pressed[blpd_pkg::BTN_STAR]  = star_pressed;
    pressed[blpd_pkg::BTN_NUM]   = num_pressed;
    pressed[blpd_pkg::BTN_UP]    = up_pressed;
    pressed[blpd_pkg::BTN_DOWN]  = down_pressed;
    pressed[blpd_pkg::BTN_LIGHT] = light_pressed;
  end

  blpd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pressed  (pressed),
    .take     (take),
    .stage    (stage)
  );

  blpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign star_press_long = result.long_pulse[blpd_pkg::BTN_STAR];
  assign num_press_long  = result.long_pulse[blpd_pkg::BTN_NUM];
  assign up_long         = result.long_pulse[blpd_pkg::BTN_UP];
  assign down_press_long = result.long_pulse[blpd_pkg::BTN_DOWN];
  assign light_long      = result.long_pulse[blpd_pkg::BTN_LIGHT];
  assign mute_state      = result.mute_state;
  assign lock_state      = result.lock_state;
  assign mute_toggled    = result.mute_toggled;
  assign lock_toggled    = result.lock_toggled;

endmodule

`default_nettype wire

// ===== rtl/blpd_in_stage.sv =====
// input register of the button long-press detector
// depends on blpd_pkg
`default_nettype none

module blpd_in_stage (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [blpd_pkg::NUM_BUTTONS-1:0]    pressed,
  input  wire logic                                take,
  output blpd_pkg::stage_t                         stage
);

  logic load;

  // the register frees up in the same cycle that its word moves on
  assign load     = !stage.valid || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= in_valid;
    end
    if (load && in_valid) begin
      stage.pressed <= pressed;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpd_core.sv =====
// counter state, combo and long-press logic, and the result register
// depends on blpd_pkg
`default_nettype none

module blpd_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire blpd_pkg::count_t       threshold,
  input  wire blpd_pkg::stage_t       stage,
  output logic                        take,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output blpd_pkg::result_t           result
);

  localparam int N = blpd_pkg::NUM_BUTTONS;

  blpd_pkg::count_t mute_count, mute_count_next;
  blpd_pkg::count_t lock_count, lock_count_next;
  blpd_pkg::count_t held_count [N];
  blpd_pkg::count_t held_count_next [N];
  logic             mute_flag, mute_flag_next;
  logic             lock_flag, lock_flag_next;
  blpd_pkg::result_t result_next;

  logic mute_combo;
  logic lock_combo;
  logic mute_fire;
  logic lock_fire;
  logic out_load;
  blpd_pkg::count_t held_inc [N];

  assign out_load = !out_valid || !out_stall;
  assign take     = stage.valid && out_load;

  assign mute_combo = stage.pressed[blpd_pkg::BTN_STAR] && stage.pressed[blpd_pkg::BTN_UP];
  assign lock_combo = stage.pressed[blpd_pkg::BTN_NUM] && stage.pressed[blpd_pkg::BTN_DOWN];
  // combo counters compare the old value, before the increment
  assign mute_fire  = mute_combo && (mute_count > threshold);
  assign lock_fire  = !mute_combo && lock_combo && (lock_count > threshold);

  always_comb begin
    mute_count_next = mute_count;
    lock_count_next = lock_count;
    mute_flag_next  = mute_flag ^ mute_fire;
    lock_flag_next  = lock_flag ^ lock_fire;
    result_next     = '0;
    for (int i = 0; i < N; i++) begin
      held_inc[i]        = held_count[i] + blpd_pkg::count_t'(1);
      held_count_next[i] = held_count[i];
    end

    if (mute_combo) begin
      mute_count_next = mute_fire ? '0 : mute_count + blpd_pkg::count_t'(1);
    end else if (lock_combo) begin
      lock_count_next = lock_fire ? '0 : lock_count + blpd_pkg::count_t'(1);
    end else begin
      // mute combo count is kept here on purpose
      lock_count_next = '0;
      for (int i = 0; i < N; i++) begin
        if (stage.pressed[i] && (held_inc[i] > threshold)) begin
          result_next.long_pulse[i] = 1'b1;
          held_count_next[i]        = '0;
        end else if (stage.pressed[i]) begin
          held_count_next[i] = held_inc[i];
        end else begin
          held_count_next[i] = '0;
        end
      end
    end

    result_next.mute_state   = mute_flag_next;
    result_next.lock_state   = lock_flag_next;
    result_next.mute_toggled = mute_fire;
    result_next.lock_toggled = lock_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_count <= '0;
      lock_count <= '0;
      mute_flag  <= 1'b0;
      lock_flag  <= 1'b0;
      for (int i = 0; i < N; i++) begin
        held_count[i] <= '0;
      end
    end else if (take) begin
      mute_count <= mute_count_next;
      lock_count <= lock_count_next;
      mute_flag  <= mute_flag_next;
      lock_flag  <= lock_flag_next;
      for (int i = 0; i < N; i++) begin
        held_count[i] <= held_count_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpd_checker.sv =====
// port-level checks for the button long-press detector, bound to the top level
// depends on button_long_press_detector only through the bind below
`default_nettype none

module blpd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic star_press_long,
  input wire logic num_press_long,
  input wire logic up_long,
  input wire logic down_press_long,
  input wire logic light_long,
  input wire logic mute_state,
  input wire logic lock_state,
  input wire logic mute_toggled,
  input wire logic lock_toggled
);

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  // only one combo can act in a tick
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mute_toggled && lock_toggled))
    else $error("mute and lock toggled in the same tick");

  // a toggle tick is a combo tick, so no single-button pulse may fire
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (mute_toggled || lock_toggled) |->
      !(star_press_long || num_press_long || up_long || down_press_long || light_long))
    else $error("long-press pulse on a combo tick");

  // star with up, or num with down, is a combo and never two long presses
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(star_press_long && up_long) && !(num_press_long && down_press_long))
    else $error("long-press pulses on both buttons of a combo");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mute_state) && $stable(lock_state)
      && $stable(mute_toggled) && $stable(lock_toggled))
    else $error("stalled result word changed");

endmodule

bind button_long_press_detector blpd_checker u_blpd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .star_press_long (star_press_long),
  .num_press_long  (num_press_long),
  .up_long         (up_long),
  .down_press_long (down_press_long),
  .light_long      (light_long),
  .mute_state      (mute_state),
  .lock_state      (lock_state),
  .mute_toggled    (mute_toggled),
  .lock_toggled    (lock_toggled)
);

`default_nettype wire
